FILE: sv/hee_pkg.sv
// Shared types, entity table and lookup functions for the HTML entity escaper.
package hee_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SelW    = 5;
  localparam int unsigned PosW    = 3;
  localparam int unsigned EntChars = 7;

  // Selector value meaning "plain byte, no entity"
  localparam logic [SelW-1:0] ENT_NONE = '0;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             final_byte;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             string_end;
  } out_t;

  // Classified request held between front and back
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic [SelW-1:0]  ent_sel;
    logic             final_byte;
  } item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a byte to its entity number plus one, or ENT_NONE
  function automatic logic [SelW-1:0] ent_classify(input logic [ByteW-1:0] b);
    logic [SelW-1:0] sel;
    unique case (b)
      8'h22:   sel = 5'd1;
      8'h26:   sel = 5'd2;
      8'hB0:   sel = 5'd3;
      8'hB2:   sel = 5'd4;
      8'hB3:   sel = 5'd5;
      8'hB4:   sel = 5'd6;
      8'hB5:   sel = 5'd7;
      8'h80:   sel = 5'd8;
      8'hA7:   sel = 5'd9;
      8'hE4:   sel = 5'd10;
      8'hC4:   sel = 5'd11;
      8'hF6:   sel = 5'd12;
      8'hD6:   sel = 5'd13;
      8'hFC:   sel = 5'd14;
      8'hDC:   sel = 5'd15;
      8'hDF:   sel = 5'd16;
      default: sel = ENT_NONE;
    endcase
    return sel;
  endfunction

  // Entity text, left aligned and padded with spaces to seven characters
  function automatic logic [8*EntChars-1:0] ent_text(input logic [SelW-1:0] sel);
    logic [8*EntChars-1:0] t;
    unique case (sel)
      5'd1:    t = "&quot; ";
      5'd2:    t = "&amp;  ";
      5'd3:    t = "&#176; ";
      5'd4:    t = "&sup2; ";
      5'd5:    t = "&sup3; ";
      5'd6:    t = "&acute;";
      5'd7:    t = "&micro;";
      5'd8:    t = "&#8364;";
      5'd9:    t = "&#167; ";
      5'd10:   t = "&auml; ";
      5'd11:   t = "&Auml; ";
      5'd12:   t = "&ouml; ";
      5'd13:   t = "&Ouml; ";
      5'd14:   t = "&uuml; ";
      5'd15:   t = "&Uuml; ";
      5'd16:   t = "&szlig;";
      default: t = "       ";
    endcase
    return t;
  endfunction

  // Entity length in characters, 5 to 7
  function automatic logic [PosW-1:0] ent_len(input logic [SelW-1:0] sel);
    logic [PosW-1:0] n;
    unique case (sel)
      5'd2:                               n = 3'd5;
      5'd6, 5'd7, 5'd8, 5'd16:            n = 3'd7;
      default:                            n = 3'd6;
    endcase
    return n;
  endfunction

  // One character of an entity
  function automatic logic [ByteW-1:0] ent_char(input logic [SelW-1:0] sel,
                                                input logic [PosW-1:0] pos);
    logic [8*EntChars-1:0] t;
    logic [5:0]            lsb;
    t   = ent_text(sel);
    lsb = 6'(8 * (6 - int'(pos)));
    return t[lsb +: 8];
  endfunction

endpackage

FILE: sv/hee_front.sv
// Front end: accepts text bytes and classifies them against the entity table.
module hee_front (
  input  logic          push,
  input  hee_pkg::in_t  item,
  input  hee_pkg::q_stat_t stat,
  output logic          wr_en,
  output hee_pkg::item_t wr_data
);
  import hee_pkg::*;

  // Take a request whenever the queue has room
  assign wr_en = push && !stat.full;

  // Look up the entity selector for the byte
  always_comb begin
    wr_data.in_byte    = item.in_byte;
    wr_data.ent_sel    = ent_classify(item.in_byte);
    wr_data.final_byte = item.final_byte;
  end

endmodule

FILE: sv/hee_fifo.sv
// Short show-ahead queue of classified requests between front and back.
module hee_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  hee_pkg::item_t   wr_data,
  input  logic             rd_en,
  output hee_pkg::item_t   rd_data,
  output hee_pkg::q_stat_t stat
);
  import hee_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = mem[rptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !stat.empty)
    else $error("queue read while empty");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !stat.full)
    else $error("queue written while full");

endmodule

FILE: sv/hee_back.sv
// Back end: expands queued requests into result bytes through an output register.
module hee_back (
  input  logic             clk,
  input  logic             rst,
  input  hee_pkg::item_t   head,
  input  hee_pkg::q_stat_t stat,
  output logic             rd_en,
  input  logic             pop,
  output logic             empty,
  output hee_pkg::out_t    result
);
  import hee_pkg::*;

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic            ovalid;
  out_t            odata;
  logic            load;
  logic            plain;
  logic            last;
  logic [ByteW-1:0] ch;

  assign plain = (head.ent_sel == ENT_NONE);
  assign last  = plain || (pos == ent_len(head.ent_sel) - 3'd1);
  assign ch    = plain ? head.in_byte : ent_char(head.ent_sel, pos);

  // Fill the output register when it is free or being drained
  assign load  = !stat.empty && (!ovalid || pop);
  assign rd_en = load && last;

  assign pos_next = last ? '0 : pos + 3'd1;
  assign empty    = !ovalid;
  assign result   = odata;

  // Step through the entity characters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        pos <= pos_next;
      end
      if (load) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Hold the result byte and its marks
  always_ff @(posedge clk) begin
    if (load) begin
      odata.out_byte   <= ch;
      odata.run_last   <= last;
      odata.string_end <= last && head.final_byte;
    end
  end

  a_plain_at_start: assert property (@(posedge clk) disable iff (rst)
    (!stat.empty && plain) |-> (pos == '0))
    else $error("plain byte met mid-expansion");

  a_pos_in_entity: assert property (@(posedge clk) disable iff (rst)
    (!stat.empty && !plain) |-> (pos < ent_len(head.ent_sel)))
    else $error("position beyond entity length");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> (pos == '0))
    else $error("position left over with queue empty");

endmodule

FILE: sv/html_entity_escaper.sv
// Top level of the HTML entity escaper: front classifier, request queue, back expander.
// An accepted byte is written into the request queue, then to the output register.
// Throughput: one result byte per cycle while requests are queued and pop is high;
// a plain byte yields one byte, an entity five to seven, one character a cycle.
// Input is taken back to back while the queue of DEPTH requests has room.
// Reset (rst, synchronous, active high) empties the queue and the output register.
module html_entity_escaper #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hee_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output hee_pkg::out_t result
);
  import hee_pkg::*;

  logic    wr_en;
  item_t   wr_data;
  logic    rd_en;
  item_t   head;
  q_stat_t stat;

  assign full = stat.full;

  hee_front u_front (
    .push    (push),
    .item    (item),
    .stat    (stat),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  hee_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (head),
    .stat    (stat)
  );

  hee_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .stat   (stat),
    .rd_en  (rd_en),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

FILE: tb/html_entity_escaper_test.sv
// Self-checking testbench for the HTML entity escaper: directed and random byte streams.
`timescale 1ns / 1ps

module html_entity_escaper_test;
  import hee_pkg::*;

  // Bytes that expand into an entity, then the plain NUL byte
  localparam logic [7:0] C_QUOT   = 8'h22;
  localparam logic [7:0] C_AMP    = 8'h26;
  localparam logic [7:0] C_DEG    = 8'hB0;
  localparam logic [7:0] C_SUP2   = 8'hB2;
  localparam logic [7:0] C_SUP3   = 8'hB3;
  localparam logic [7:0] C_ACUTE  = 8'hB4;
  localparam logic [7:0] C_MICRO  = 8'hB5;
  localparam logic [7:0] C_EURO   = 8'h80;
  localparam logic [7:0] C_SECT   = 8'hA7;
  localparam logic [7:0] C_AUML_L = 8'hE4;
  localparam logic [7:0] C_AUML_U = 8'hC4;
  localparam logic [7:0] C_OUML_L = 8'hF6;
  localparam logic [7:0] C_OUML_U = 8'hD6;
  localparam logic [7:0] C_UUML_L = 8'hFC;
  localparam logic [7:0] C_UUML_U = 8'hDC;
  localparam logic [7:0] C_SZLIG  = 8'hDF;
  localparam logic [7:0] C_NUL    = 8'h00;

  localparam logic [7:0] SPECIAL_BYTES [16] = '{
    C_QUOT, C_AMP, C_DEG, C_SUP2, C_SUP3, C_ACUTE, C_MICRO, C_EURO,
    C_SECT, C_AUML_L, C_AUML_U, C_OUML_L, C_OUML_U, C_UUML_L, C_UUML_U, C_SZLIG
  };

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 25;

  logic  clk = 1'b0;
  logic  rst;
  logic  push;
  logic  full;
  in_t   item;
  logic  empty;
  logic  pop;
  out_t  result;

  out_t  pending_output [$];
  int    errors      = 0;
  int    cycle_count = 0;
  bit    steady_flow = 1'b0;

  html_entity_escaper DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // Clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Drain results, stalling at random unless the flow is steady
  always @(posedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Entity text for a byte, empty string for a plain byte
  function automatic string entity_text(input logic [7:0] b);
    case (b)
      C_QUOT:   return "&quot;";
      C_AMP:    return "&amp;";
      C_DEG:    return "&#176;";
      C_SUP2:   return "&sup2;";
      C_SUP3:   return "&sup3;";
      C_ACUTE:  return "&acute;";
      C_MICRO:  return "&micro;";
      C_EURO:   return "&#8364;";
      C_SECT:   return "&#167;";
      C_AUML_L: return "&auml;";
      C_AUML_U: return "&Auml;";
      C_OUML_L: return "&ouml;";
      C_OUML_U: return "&Ouml;";
      C_UUML_L: return "&uuml;";
      C_UUML_U: return "&Uuml;";
      C_SZLIG:  return "&szlig;";
      default:  return "";
    endcase
  endfunction

  // Queue the result bytes that one request expands into
  task automatic expand_request(input in_t req);
    string s;
    out_t  r;
    s = entity_text(req.in_byte);
    if (s.len() == 0) begin
      r.out_byte   = req.in_byte;
      r.run_last   = 1'b1;
      r.string_end = req.final_byte;
      pending_output.push_back(r);
    end else begin
      for (int i = 0; i < s.len(); i++) begin
        r.out_byte   = s[i];
        r.run_last   = (i == s.len() - 1);
        r.string_end = r.run_last && req.final_byte;
        pending_output.push_back(r);
      end
    end
  endtask

  // Compare one popped result with the oldest expectation
  task automatic check_result(input out_t got);
    out_t want;
    if (pending_output.size() == 0) begin
      $display("%0t: unexpected result byte=%h last=%b end=%b",
               $time, got.out_byte, got.run_last, got.string_end);
      errors++;
    end else begin
      want = pending_output.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last expected %b actual %b", $time, want.run_last, got.run_last);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $display("%0t: string_end expected %b actual %b",
                 $time, want.string_end, got.string_end);
        errors++;
      end
    end
  endtask

  // Watch both handshakes; values read here are those before the edge
  always @(posedge clk) begin
    if (!rst && push && !full)
      expand_request(item);
    if (!rst && pop && !empty)
      check_result(result);
  end

  // Send one request, with a random gap in front unless the flow is steady
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    push            <= 1'b1;
    item.in_byte    <= b;
    item.final_byte <= fin;
    do @(posedge clk); while (full);
  endtask

  // Hold the sender until every expected result has come
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_output.size() != 0) @(posedge clk);
  endtask

  // Pick a byte, biased towards the special ones
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return SPECIAL_BYTES[$urandom_range(15)];
    if (r < 40) return C_NUL;
    return 8'($urandom_range(255));
  endfunction

  // Every entity once, final mark alternating
  task automatic test_each_entity();
    for (int i = 0; i < 16; i++)
      send_byte(SPECIAL_BYTES[i], i[0]);
  endtask

  // Plain bytes at the field extremes, NUL passing through as a terminator
  task automatic test_plain_extremes();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h81, 1'b1);
    send_byte(C_NUL, 1'b1);
  endtask

  // Short string with final on an entity, then a lone final byte
  task automatic test_final_marks();
    send_byte(8'h41, 1'b0);
    send_byte(C_SZLIG, 1'b1);
    send_byte(C_AMP, 1'b1);
    wait_drained();
  endtask

  // Random strings, final on the last byte and now and then mid-string
  task automatic test_random_strings(input int total);
    int sent;
    int len;
    logic fin;
    sent = 0;
    while (sent < total) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        fin = (i == len - 1) || ($urandom_range(99) < 5);
        send_byte(pick_byte(), fin);
      end
      sent += len;
      // Run flat out for a stretch in the middle
      if (sent > total / 3 && sent < total / 2)
        steady_flow = 1'b1;
      else
        steady_flow = 1'b0;
      if (sent > (2 * total) / 3 && sent - len <= (2 * total) / 3)
        wait_drained();
    end
  endtask

  initial begin
    rst             <= 1'b1;
    push            <= 1'b0;
    item.in_byte    <= '0;
    item.final_byte <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_each_entity();
    test_plain_extremes();
    test_final_marks();
    test_random_strings(250);

    // Let the last results drain
    push <= 1'b0;
    while (pending_output.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0 && pending_output.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
sv/hee_pkg.sv
sv/hee_front.sv
sv/hee_fifo.sv
sv/hee_back.sv
sv/html_entity_escaper.sv
tb/html_entity_escaper_test.sv
